### hw/rtl/cca_pkg.sv
`timescale 1ns / 1ps

package cca_pkg;

  localparam int CFG_W     = 11;
  localparam int COORD_W   = 10;
  localparam int IDX_W     = 20;
  localparam int KIDX_W    = 6;
  localparam int KDIM_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int AX_W      = 14;

  localparam int DEF_MAX_IMAGE_DIM  = 1024;
  localparam int DEF_MAX_KERNEL_DIM = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
  } pixel_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  matrix_row;
    logic [IDX_W-1:0]  matrix_col;
    logic [KIDX_W-1:0] kernel_index;
    logic              last_entry;
  } matrix_entry_t;

  typedef struct packed {
    logic [KDIM_W-1:0] pre;
    logic [KDIM_W-1:0] post;
    logic [KDIM_W-1:0] off;
  } axis_win_t;

  typedef struct packed {
    logic [IDX_W-1:0]  mrow;
    logic [IDX_W-1:0]  base;
    logic [KIDX_W-1:0] kbase;
    logic [KDIM_W-1:0] nrows;
    logic [KDIM_W-1:0] ncols;
    logic [CFG_W-1:0]  step;
    logic [KDIM_W-1:0] kstep;
  } window_desc_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  function automatic logic [CFG_W-1:0] clamp_image(logic [CFG_W-1:0] v, int maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (int'(v) > maxv) begin
      r = CFG_W'(maxv);
    end
    return r;
  endfunction

  function automatic logic [KDIM_W-1:0] clamp_kernel(logic [KDIM_W-1:0] v, int maxv);
    logic [KDIM_W-1:0] r;
    r = v;
    if (int'(v) > maxv) begin
      r = KDIM_W'(maxv);
    end
    return r;
  endfunction

  // The nominal pre extent is n/2 rounded down for both parities, and the
  // nominal post extent is the remainder of the kernel size.
  function automatic axis_win_t axis_window(logic [COORD_W-1:0] k, logic [KDIM_W-1:0] n,
                                            logic [CFG_W-1:0] m);
    logic signed [AX_W-1:0] ks;
    logic signed [AX_W-1:0] ms;
    logic signed [AX_W-1:0] p;
    logic signed [AX_W-1:0] q;
    logic signed [AX_W-1:0] pre;
    logic signed [AX_W-1:0] post;
    logic signed [AX_W-1:0] off;
    axis_win_t w;
    ks = AX_W'(k);
    ms = AX_W'(m);
    p  = AX_W'(n >> 1);
    q  = AX_W'(n) - p;
    if (ks < p) begin
      pre  = ks;
      post = q;
      off  = p - ks;
    end else if (ks > ms - q - AX_W'(1)) begin
      pre  = p;
      post = ms - ks;
      off  = '0;
    end else begin
      pre  = p;
      post = q;
      off  = '0;
    end
    if (post > ms - ks) begin
      post = ms - ks;
    end
    if (post < 0) begin
      post = '0;
    end
    w.pre  = KDIM_W'(pre);
    w.post = KDIM_W'(post);
    w.off  = KDIM_W'(off);
    return w;
  endfunction

endpackage

### hw/rtl/cca_front.sv
`timescale 1ns / 1ps

module cca_front #(
  parameter int MAX_IMAGE_DIM  = cca_pkg::DEF_MAX_IMAGE_DIM,
  parameter int MAX_KERNEL_DIM = cca_pkg::DEF_MAX_KERNEL_DIM
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  cca_pkg::pixel_req_t            pixel,
  input  logic                           cfg_write,
  input  logic [cca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cca_pkg::CFG_W-1:0]      cfg_data,
  output logic                           q_push,
  output cca_pkg::window_desc_t          q_data,
  input  logic                           q_full
);
  import cca_pkg::*;

  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [KDIM_W-1:0]  kernel_width;
  logic [KDIM_W-1:0]  kernel_height;

  logic [CFG_W-1:0]   w;
  logic [CFG_W-1:0]   h;
  logic [KDIM_W-1:0]  kw;
  logic [KDIM_W-1:0]  kh;

  logic               accept;
  logic               drain;
  logic               in_empty;

  logic               a_valid;
  logic               a_empty;
  logic [COORD_W-1:0] a_row;
  logic [COORD_W-1:0] a_col;
  axis_win_t          a_x;
  axis_win_t          a_y;

  logic [COORD_W-1:0] start_row;
  logic [COORD_W-1:0] start_col;
  logic [IDX_W:0]     mrow_full;
  logic [IDX_W:0]     base_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= CFG_W'(64);
      image_height  <= CFG_W'(64);
      kernel_width  <= KDIM_W'(3);
      kernel_height <= KDIM_W'(3);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[KDIM_W-1:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign w  = clamp_image(image_width, MAX_IMAGE_DIM);
  assign h  = clamp_image(image_height, MAX_IMAGE_DIM);
  assign kw = clamp_kernel(kernel_width, MAX_KERNEL_DIM);
  assign kh = clamp_kernel(kernel_height, MAX_KERNEL_DIM);

  // A request that yields no entries is dropped here and never reaches the queue.
  assign in_empty = (w == '0) || (h == '0) || (kw == '0) || (kh == '0) ||
                    ({1'b0, pixel.pixel_row} >= h) || ({1'b0, pixel.pixel_col} >= w);

  assign drain  = a_valid && (a_empty || !q_full);
  assign busy   = a_valid && !drain;
  assign accept = start && !busy;
  assign q_push = drain && !a_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (drain) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_row   <= pixel.pixel_row;
      a_col   <= pixel.pixel_col;
      a_empty <= in_empty;
      a_x     <= axis_window(pixel.pixel_col, kw, w);
      a_y     <= axis_window(pixel.pixel_row, kh, h);
    end
  end

  assign start_row = a_row - COORD_W'(a_y.pre);
  assign start_col = a_col - COORD_W'(a_x.pre);
  assign mrow_full = (IDX_W+1)'(a_row) * (IDX_W+1)'(w) + (IDX_W+1)'(a_col);
  assign base_full = (IDX_W+1)'(start_row) * (IDX_W+1)'(w) + (IDX_W+1)'(start_col);

  always_comb begin
    q_data.mrow  = mrow_full[IDX_W-1:0];
    q_data.base  = base_full[IDX_W-1:0];
    q_data.kbase = KIDX_W'(a_y.off) * KIDX_W'(kw) + KIDX_W'(a_x.off);
    q_data.nrows = a_y.pre + a_y.post;
    q_data.ncols = a_x.pre + a_x.post;
    q_data.step  = w;
    q_data.kstep = kw;
  end

  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("Window pushed into a full queue.");
  assert property (@(posedge clk) disable iff (rst) busy |-> (q_full && !a_empty))
    else $error("Front stalled without a full queue.");

endmodule

### hw/rtl/cca_queue.sv
`timescale 1ns / 1ps

module cca_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cca_pkg::window_desc_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output cca_pkg::window_desc_t head
);
  import cca_pkg::*;

  window_desc_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [1:0]   count_next;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (pop && !push) |-> valid)
    else $error("Queue popped while empty.");

endmodule

### hw/rtl/cca_back.sv
`timescale 1ns / 1ps

module cca_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  cca_pkg::window_desc_t  q_head,
  output logic                   q_pop,
  output cca_pkg::matrix_entry_t entry,
  output logic                   entry_strobe
);
  import cca_pkg::*;

  seq_state_t        state;
  seq_state_t        state_next;
  window_desc_t      cur;
  logic [KDIM_W-1:0] r_cnt;
  logic [KDIM_W-1:0] c_cnt;
  logic [IDX_W-1:0]  row_base;
  logic [IDX_W-1:0]  col_idx;
  logic [KIDX_W-1:0] krow;
  logic [KIDX_W-1:0] kidx;
  logic              last_now;
  logic              row_end;
  logic              load;
  logic              emit;

  assign row_end  = (c_cnt == cur.ncols - KDIM_W'(1));
  assign last_now = row_end && (r_cnt == cur.nrows - KDIM_W'(1));
  assign q_pop    = load;

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (q_valid) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (last_now && !q_valid) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    emit = 1'b0;
    case (state)
      SEQ_IDLE: begin
        load = q_valid;
      end
      SEQ_RUN: begin
        emit = 1'b1;
        load = q_valid && last_now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SEQ_IDLE;
      entry_strobe <= 1'b0;
    end else begin
      state        <= state_next;
      entry_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      entry.matrix_row   <= cur.mrow;
      entry.matrix_col   <= col_idx;
      entry.kernel_index <= kidx;
      entry.last_entry   <= last_now;
    end
    if (load) begin
      cur      <= q_head;
      r_cnt    <= '0;
      c_cnt    <= '0;
      row_base <= q_head.base;
      col_idx  <= q_head.base;
      krow     <= q_head.kbase;
      kidx     <= q_head.kbase;
    end else if (emit && !last_now) begin
      if (row_end) begin
        r_cnt    <= r_cnt + KDIM_W'(1);
        c_cnt    <= '0;
        row_base <= row_base + IDX_W'(cur.step);
        col_idx  <= row_base + IDX_W'(cur.step);
        krow     <= krow + KIDX_W'(cur.kstep);
        kidx     <= krow + KIDX_W'(cur.kstep);
      end else begin
        c_cnt   <= c_cnt + KDIM_W'(1);
        col_idx <= col_idx + IDX_W'(1);
        kidx    <= kidx + KIDX_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("Sequencer took a window from an empty queue.");
  assert property (@(posedge clk) disable iff (rst)
                   (state == SEQ_RUN) |-> ((c_cnt < cur.ncols) && (r_cnt < cur.nrows)))
    else $error("Window counters ran past the window.");
  assert property (@(posedge clk) disable iff (rst) entry_strobe |-> $past(state == SEQ_RUN))
    else $error("Entry strobe without a running window.");

endmodule

### hw/rtl/clipped_convolution_matrix_addresser.sv
`timescale 1ns / 1ps

// Channel   Ports                          Handshake
// request   start, busy, pixel             taken when start is high and busy is low
// entry     entry_strobe, entry            strobed once per entry, no back-pressure
// config    cfg_write, cfg_index, cfg_data written when cfg_write is high
//
// A pixel's first entry is registered in the front, the queue and the sequencer
// on its way to the entry output. Entries leave one per cycle while the sequencer
// holds a window; an R by C window yields R*C entries, which sets the sustained
// rate. A two-entry window queue lets requests be taken while the sequencer is
// busy; busy rises only when that queue is full. Pixels that yield no entries
// never reach the queue. Reset restores the register defaults and empties the queue.

module clipped_convolution_matrix_addresser #(
  parameter int MAX_IMAGE_DIM  = cca_pkg::DEF_MAX_IMAGE_DIM,
  parameter int MAX_KERNEL_DIM = cca_pkg::DEF_MAX_KERNEL_DIM
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  cca_pkg::pixel_req_t            pixel,
  output logic                           entry_strobe,
  output cca_pkg::matrix_entry_t         entry,
  input  logic                           cfg_write,
  input  logic [cca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cca_pkg::CFG_W-1:0]      cfg_data
);
  import cca_pkg::*;

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  window_desc_t q_data;
  window_desc_t q_head;

  cca_front #(
    .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
    .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  cca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  cca_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .entry        (entry),
    .entry_strobe (entry_strobe)
  );

endmodule

### sim/clipped_convolution_matrix_addresser_tb.sv
`timescale 1ns / 1ps

module clipped_convolution_matrix_addresser_tb;
  import cca_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_PHASES = 8;

  typedef struct packed {
    logic              set_cfg;
    logic [CFG_W-1:0]  iw;
    logic [CFG_W-1:0]  ih;
    logic [KDIM_W-1:0] kw;
    logic [KDIM_W-1:0] kh;
    pixel_req_t        px;
    logic              typed;
    logic              one_entry;
    matrix_entry_t     ent;
  } stim_row_t;

  localparam int DIR_ROWS = 24;

  stim_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd0, 10'd0}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd63, 10'd63}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd10, 10'd20}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd64, 10'd0}, 1'b1, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd0, 10'd64}, 1'b1, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd1023, 10'd1023}, 1'b1, 1'b0, '0},
    '{1'b1, 11'd1024, 11'd1024, 4'd1, 4'd1, '{10'd1023, 10'd1023}, 1'b1, 1'b1,
      '{20'hFFFFF, 20'hFFFFF, 6'd0, 1'b1}},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd0, 10'd0}, 1'b1, 1'b1,
      '{20'h00000, 20'h00000, 6'd0, 1'b1}},
    '{1'b1, 11'd2047, 11'd2047, 4'd15, 4'd15, '{10'd1023, 10'd1023}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd0, 10'd0}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd500, 10'd500}, 1'b0, 1'b0, '0},
    '{1'b1, 11'd0, 11'd64, 4'd3, 4'd3, '{10'd0, 10'd0}, 1'b1, 1'b0, '0},
    '{1'b1, 11'd5, 11'd0, 4'd3, 4'd3, '{10'd0, 10'd0}, 1'b1, 1'b0, '0},
    '{1'b1, 11'd8, 11'd8, 4'd0, 4'd3, '{10'd2, 10'd2}, 1'b1, 1'b0, '0},
    '{1'b1, 11'd8, 11'd8, 4'd3, 4'd0, '{10'd2, 10'd2}, 1'b1, 1'b0, '0},
    '{1'b1, 11'd1, 11'd1, 4'd8, 4'd8, '{10'd0, 10'd0}, 1'b0, 1'b0, '0},
    '{1'b1, 11'd7, 11'd5, 4'd4, 4'd5, '{10'd0, 10'd0}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd4, 10'd6}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd2, 10'd3}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd1, 10'd5}, 1'b0, 1'b0, '0},
    '{1'b1, 11'd2, 11'd1023, 4'd7, 4'd2, '{10'd1022, 10'd1}, 1'b0, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, 4'd0, 4'd0, '{10'd0, 10'd0}, 1'b0, 1'b0, '0},
    '{1'b1, 11'd1024, 11'd1, 4'd1, 4'd8, '{10'd0, 10'd1023}, 1'b0, 1'b0, '0},
    '{1'b1, 11'd9, 11'd9, 4'd6, 4'd6, '{10'd8, 10'd8}, 1'b0, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  pixel_req_t           pixel = '0;
  logic                 entry_strobe;
  matrix_entry_t        entry;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [CFG_W-1:0]  img_w_reg = 11'd64;
  logic [CFG_W-1:0]  img_h_reg = 11'd64;
  logic [KDIM_W-1:0] ker_w_reg = 4'd3;
  logic [KDIM_W-1:0] ker_h_reg = 4'd3;

  matrix_entry_t expected_entries [$];
  int            err_count = 0;
  int            idle_cycles = 0;

  clipped_convolution_matrix_addresser dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel        (pixel),
    .entry_strobe (entry_strobe),
    .entry        (entry),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    if (err_count < 50) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic void queue_expected(input matrix_entry_t e);
    expected_entries.insert(expected_entries.size(), e);
  endfunction

  function automatic int img_dim(input logic [CFG_W-1:0] v);
    return (v > DEF_MAX_IMAGE_DIM) ? DEF_MAX_IMAGE_DIM : int'(v);
  endfunction

  function automatic int ker_dim(input logic [KDIM_W-1:0] v);
    return (v > DEF_MAX_KERNEL_DIM) ? DEF_MAX_KERNEL_DIM : int'(v);
  endfunction

  function automatic void clip_axis(input int k, input int n, input int m,
                                    output int lo, output int hi, output int koff);
    int q;
    if (n % 2 == 0) begin
      q = n / 2;
      if (k < q) begin
        lo = k;
        hi = q;
        koff = q - k;
      end else if (k > m - q - 1) begin
        lo = q;
        hi = m - k;
        koff = 0;
      end else begin
        lo = q;
        hi = q;
        koff = 0;
      end
    end else begin
      q = (n + 1) / 2;
      if (k < q - 1) begin
        lo = k;
        hi = q;
        koff = q - 1 - k;
      end else if (k > m - q - 1) begin
        lo = q - 1;
        hi = m - k;
        koff = 0;
      end else begin
        lo = q - 1;
        hi = q;
        koff = 0;
      end
    end
    if (hi > m - k) begin
      hi = m - k;
    end
    if (hi < 0) begin
      hi = 0;
    end
  endfunction

  function automatic void expand_pixel(input pixel_req_t px);
    int w, h, kw, kh, row, col;
    int left, right, offx, top, bottom, offy;
    int total, n, r, c;
    matrix_entry_t e;
    w   = img_dim(img_w_reg);
    h   = img_dim(img_h_reg);
    kw  = ker_dim(ker_w_reg);
    kh  = ker_dim(ker_h_reg);
    row = int'(px.pixel_row);
    col = int'(px.pixel_col);
    if (w == 0 || h == 0 || kw == 0 || kh == 0 || row >= h || col >= w) begin
      return;
    end
    clip_axis(col, kw, w, left, right, offx);
    clip_axis(row, kh, h, top, bottom, offy);
    total = (top + bottom) * (left + right);
    if (total <= 0) begin
      return;
    end
    n = 0;
    for (r = row - top; r < row + bottom; r++) begin
      for (c = col - left; c < col + right; c++) begin
        n++;
        e.matrix_row   = IDX_W'(row * w + col);
        e.matrix_col   = IDX_W'(r * w + c);
        e.kernel_index = KIDX_W'((offy + r - row + top) * kw + offx + c - col + left);
        e.last_entry   = (n == total);
        queue_expected(e);
      end
    end
  endfunction

  task automatic send_pixel(input pixel_req_t px);
    start <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] iw, input logic [CFG_W-1:0] ih,
                              input logic [CFG_W-1:0] kw, input logic [CFG_W-1:0] kh);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= iw;
    @(posedge clk);
    img_w_reg = iw;
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= ih;
    @(posedge clk);
    img_h_reg = ih;
    cfg_index <= REG_KERNEL_WIDTH;
    cfg_data  <= kw;
    @(posedge clk);
    ker_w_reg = kw[KDIM_W-1:0];
    cfg_index <= REG_KERNEL_HEIGHT;
    cfg_data  <= kh;
    @(posedge clk);
    ker_h_reg = kh[KDIM_W-1:0];
    cfg_write <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_image_dim();
    case ($urandom_range(0, 9))
      0: return CFG_W'($urandom_range(1025, 2047));
      1: return CFG_W'(1024);
      2: return CFG_W'($urandom_range(17, 1023));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_kernel_data();
    logic [CFG_W-1:0] d;
    d = CFG_W'($urandom);
    if ($urandom_range(0, 5) == 0) begin
      d[KDIM_W-1:0] = KDIM_W'($urandom_range(9, 15));
    end else begin
      d[KDIM_W-1:0] = KDIM_W'($urandom_range(1, 8));
    end
    return d;
  endfunction

  function automatic int pick_coord(input int m);
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 4) < m) ? $urandom_range(0, 4) : 0;
      1: return (m - 1 - int'($urandom_range(0, 4)) >= 0) ?
                m - 1 - int'($urandom_range(0, 4)) : m - 1;
      default: return $urandom_range(0, m - 1);
    endcase
  endfunction

  function automatic pixel_req_t pick_pixel();
    int w, h;
    pixel_req_t p;
    w = img_dim(img_w_reg);
    h = img_dim(img_h_reg);
    if (w == 0 || h == 0 || $urandom_range(0, 9) == 0) begin
      p.pixel_row = COORD_W'($urandom);
      p.pixel_col = COORD_W'($urandom);
    end else begin
      p.pixel_row = COORD_W'(pick_coord(h));
      p.pixel_col = COORD_W'(pick_coord(w));
    end
    return p;
  endfunction

  always @(posedge clk) begin
    matrix_entry_t want;
    if (!rst && entry_strobe) begin
      if (expected_entries.size() == 0) begin
        report_error($sformatf("unexpected entry row=%0d col=%0d k=%0d last=%0b",
                               entry.matrix_row, entry.matrix_col,
                               entry.kernel_index, entry.last_entry));
      end else begin
        want = expected_entries.pop_front();
        if (entry.matrix_row !== want.matrix_row || entry.matrix_col !== want.matrix_col ||
            entry.kernel_index !== want.kernel_index ||
            entry.last_entry !== want.last_entry) begin
          report_error($sformatf("entry got %0d/%0d/%0d/%0b want %0d/%0d/%0d/%0b",
                                 entry.matrix_row, entry.matrix_col, entry.kernel_index,
                                 entry.last_entry, want.matrix_row, want.matrix_col,
                                 want.kernel_index, want.last_entry));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || entry_strobe || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int burst_left;
    int gap;
    int n_items;
    stim_row_t row;
    pixel_req_t px;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      if (row.set_cfg) begin
        wait_idle();
        program_regs(row.iw, row.ih, CFG_W'(row.kw), CFG_W'(row.kh));
      end
      send_pixel(row.px);
      if (!row.typed) begin
        expand_pixel(row.px);
      end else if (row.one_entry) begin
        queue_expected(row.ent);
      end
    end
    wait_idle();

    burst_left = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        program_regs(CFG_W'(1024), CFG_W'($urandom_range(1025, 2047)),
                     pick_kernel_data(), pick_kernel_data());
      end else begin
        program_regs(pick_image_dim(), pick_image_dim(),
                     pick_kernel_data(), pick_kernel_data());
      end
      n_items = $urandom_range(37, 60);
      for (int i = 0; i < n_items; i++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        px = pick_pixel();
        send_pixel(px);
        expand_pixel(px);
        burst_left--;
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/cca_pkg.sv
hw/rtl/cca_front.sv
hw/rtl/cca_queue.sv
hw/rtl/cca_back.sv
hw/rtl/clipped_convolution_matrix_addresser.sv
sim/clipped_convolution_matrix_addresser_tb.sv
